// File: hdl/rchb_pkg.sv
// ----------------------------------------------------------------------------
// rchb_pkg: shared types and constants for the chunk header builder
// Message descriptor, header beat, queue entry and per-slot record layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package rchb_pkg;

    // Per-channel state table
    localparam int CHANNEL_SLOTS = 64;
    localparam int SLOT_W        = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;

    // Queue between classifier and byte sequencer
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Saturation level of the 24-bit time field
    localparam logic [23:0] TIME_SAT = 24'hFFFFFF;

    // Chunk stream id thresholds for the basic header forms
    localparam logic [16:0] CID_ONE_MAX    = 17'd63;
    localparam logic [16:0] CID_TWO_MAX    = 17'd319;
    localparam logic [16:0] CID_BIAS       = 17'd64;
    localparam logic [16:0] CID_FORCE_ZERO = 17'd2;

    // Header formats
    localparam logic [1:0] FMT_FULL      = 2'd0;
    localparam logic [1:0] FMT_NO_STREAM = 2'd1;
    localparam logic [1:0] FMT_DELTA     = 2'd2;
    localparam logic [1:0] FMT_CONT      = 2'd3;

    // Basic header length in bytes
    localparam logic [1:0] BL_ONE   = 2'd1;
    localparam logic [1:0] BL_TWO   = 2'd2;
    localparam logic [1:0] BL_THREE = 2'd3;

    typedef struct packed {
        logic [5:0]  channel_slot;
        logic [16:0] channel_id;
        logic [31:0] stream_id;
        logic [31:0] timestamp;
        logic [7:0]  msg_type;
        logic [23:0] body_size;
    } in_t;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       last_byte;
    } out_t;

    // One classified header waiting for serialization
    typedef struct packed {
        logic [1:0]  fmt;
        logic [1:0]  bl;
        logic [5:0]  cid_lo;
        logic [15:0] rel;
        logic [23:0] tfield;
        logic        ext;
        logic [7:0]  msg_type;
        logic [23:0] body_size;
        logic [31:0] stream_id;
        logic [31:0] timestamp;
    } hdr_t;

    // Stored state of one channel slot
    typedef struct packed {
        logic [31:0] stream;
        logic [31:0] abs_time;
        logic [31:0] delta;
        logic [7:0]  mtype;
        logic [23:0] size;
    } slot_rec_t;

    localparam int SLOT_REC_W = $bits(slot_rec_t);

    // Reduce a 6-bit slot field modulo the table size by restoring subtraction
    function automatic logic [SLOT_W-1:0] slot_of(input logic [5:0] raw);
        int r;
        int k;
        r = int'(raw);
        for (k = 5; k >= 0; k--) begin
            if (r >= (CHANNEL_SLOTS << k)) begin
                r = r - (CHANNEL_SLOTS << k);
            end
        end
        return SLOT_W'(r);
    endfunction

endpackage

`default_nettype wire

// File: hdl/rchb_ram.sv
// ----------------------------------------------------------------------------
// rchb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
`default_nettype none

module rchb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                       aclk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/rchb_front.sv
// ----------------------------------------------------------------------------
// rchb_front: descriptor intake and header classification
// Reads slot state, picks the header format, updates state, queues the header.
// ----------------------------------------------------------------------------
`default_nettype none

module rchb_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire rchb_pkg::in_t s_data,
    output logic               q_push,
    output rchb_pkg::hdr_t     q_data,
    input  wire logic          q_ready
);
    import rchb_pkg::*;

    logic                     accept;
    logic [SLOT_W-1:0]        in_slot;
    logic                     s1_fire;

    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    in_t                      s1_item_reg;
    logic [SLOT_W-1:0]        s1_slot_reg;
    logic                     byp_hit_reg;
    slot_rec_t                byp_data_reg;
    logic [CHANNEL_SLOTS-1:0] slot_valid_reg;

    logic [SLOT_REC_W-1:0]    ram_rdata;
    slot_rec_t                prev;
    slot_rec_t                wr_rec;
    logic [31:0]              sid;
    logic [31:0]              delta;
    logic [31:0]              tval;
    logic                     same_stream;
    logic                     same_shape;
    logic [1:0]               fmt;
    logic                     ext;
    logic [16:0]              cid_diff;
    logic [1:0]               bl;

    assign in_slot = slot_of(s_data.channel_slot);
    assign s1_fire = s1_valid_reg && q_ready;
    assign s_ready = !s1_valid_reg || q_ready;
    assign accept  = s_valid && s_ready;

    rchb_ram #(
        .WIDTH (SLOT_REC_W),
        .DEPTH (CHANNEL_SLOTS)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (s1_fire),
        .waddr (s1_slot_reg),
        .wdata (wr_rec),
        .re    (accept),
        .raddr (in_slot),
        .rdata (ram_rdata)
    );

    // The RAM read lags one write: forward the record written on the accept edge
    assign prev = byp_hit_reg ? byp_data_reg : slot_rec_t'(ram_rdata);

    always_comb begin
        sid = (s1_item_reg.channel_id == CID_FORCE_ZERO) ? 32'd0 : s1_item_reg.stream_id;
        delta = s1_item_reg.timestamp - prev.abs_time;
        same_stream = slot_valid_reg[s1_slot_reg] && (prev.stream == sid)
                      && (s1_item_reg.timestamp >= prev.abs_time);
        same_shape = (prev.mtype == s1_item_reg.msg_type)
                     && (prev.size == s1_item_reg.body_size);
        tval = same_stream ? delta : s1_item_reg.timestamp;
        if (!same_stream) begin
            fmt = FMT_FULL;
        end else if (!same_shape) begin
            fmt = FMT_NO_STREAM;
        end else if (prev.delta == delta) begin
            fmt = FMT_CONT;
        end else begin
            fmt = FMT_DELTA;
        end
        ext = (tval >= {8'd0, TIME_SAT});

        cid_diff = s1_item_reg.channel_id - CID_BIAS;
        if (s1_item_reg.channel_id > CID_TWO_MAX) begin
            bl = BL_THREE;
        end else if (s1_item_reg.channel_id > CID_ONE_MAX) begin
            bl = BL_TWO;
        end else begin
            bl = BL_ONE;
        end

        wr_rec.stream   = sid;
        wr_rec.abs_time = s1_item_reg.timestamp;
        wr_rec.delta    = tval;
        wr_rec.mtype    = s1_item_reg.msg_type;
        wr_rec.size     = s1_item_reg.body_size;

        q_data.fmt       = fmt;
        q_data.bl        = bl;
        q_data.cid_lo    = s1_item_reg.channel_id[5:0];
        q_data.rel       = cid_diff[15:0];
        q_data.tfield    = ext ? TIME_SAT : tval[23:0];
        q_data.ext       = ext;
        q_data.msg_type  = s1_item_reg.msg_type;
        q_data.body_size = s1_item_reg.body_size;
        q_data.stream_id = sid;
        q_data.timestamp = s1_item_reg.timestamp;
    end

    assign q_push = s1_fire;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            byp_hit_reg    <= 1'b0;
            slot_valid_reg <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (accept) begin
                byp_hit_reg <= s1_fire && (in_slot == s1_slot_reg);
            end
            if (s1_fire) begin
                slot_valid_reg[s1_slot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg  <= s_data;
            s1_slot_reg  <= in_slot;
            byp_data_reg <= wr_rec;
        end
    end

endmodule

`default_nettype wire

// File: hdl/rchb_queue.sv
// ----------------------------------------------------------------------------
// rchb_queue: short header queue
// Decouples the classifier from the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rchb_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire rchb_pkg::hdr_t push_data,
    output logic                ready,
    input  wire logic           pop,
    output rchb_pkg::hdr_t      pop_data,
    output logic                valid
);
    import rchb_pkg::*;

    hdr_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign ready    = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: hdl/rchb_back.sv
// ----------------------------------------------------------------------------
// rchb_back: header byte sequencer
// Walks the sections of a queued header, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module rchb_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    input  wire rchb_pkg::hdr_t q_data,
    output logic                q_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output rchb_pkg::out_t      m_data
);
    import rchb_pkg::*;

    typedef enum logic [4:0] {
        SEC_BASIC = 5'b00001,
        SEC_TIME  = 5'b00010,
        SEC_SIZE  = 5'b00100,
        SEC_SID   = 5'b01000,
        SEC_EXT   = 5'b10000
    } sec_t;

    localparam logic [5:0] ID_TWO_BYTE   = 6'd0;
    localparam logic [5:0] ID_THREE_BYTE = 6'd1;

    logic       cur_valid_reg;
    hdr_t       cur_reg;
    sec_t       sec_reg;
    logic [1:0] idx_reg;
    logic       out_valid_reg;
    out_t       out_reg;

    logic       out_load;
    logic       emit;
    logic [7:0] byte_val;
    logic [1:0] sec_last;
    sec_t       sec_next;
    logic       sec_done;
    logic       sec_end;
    logic       hdr_end;
    logic       load_cur;

    assign out_load = !out_valid_reg || m_ready;
    assign emit     = cur_valid_reg && out_load;

    always_comb begin
        byte_val = 8'd0;
        sec_last = 2'd3;
        sec_next = SEC_EXT;
        sec_done = 1'b1;
        case (sec_reg)
            SEC_BASIC: begin
                sec_last = cur_reg.bl - 1'b1;
                case (idx_reg)
                    2'd0: begin
                        if (cur_reg.bl == BL_ONE) begin
                            byte_val = {cur_reg.fmt, cur_reg.cid_lo};
                        end else if (cur_reg.bl == BL_TWO) begin
                            byte_val = {cur_reg.fmt, ID_TWO_BYTE};
                        end else begin
                            byte_val = {cur_reg.fmt, ID_THREE_BYTE};
                        end
                    end
                    2'd1:    byte_val = cur_reg.rel[7:0];
                    default: byte_val = cur_reg.rel[15:8];
                endcase
                if (cur_reg.fmt != FMT_CONT) begin
                    sec_next = SEC_TIME;
                    sec_done = 1'b0;
                end else begin
                    sec_done = !cur_reg.ext;
                end
            end
            SEC_TIME: begin
                sec_last = 2'd2;
                case (idx_reg)
                    2'd0:    byte_val = cur_reg.tfield[23:16];
                    2'd1:    byte_val = cur_reg.tfield[15:8];
                    default: byte_val = cur_reg.tfield[7:0];
                endcase
                if (cur_reg.fmt == FMT_FULL || cur_reg.fmt == FMT_NO_STREAM) begin
                    sec_next = SEC_SIZE;
                    sec_done = 1'b0;
                end else begin
                    sec_done = !cur_reg.ext;
                end
            end
            SEC_SIZE: begin
                case (idx_reg)
                    2'd0:    byte_val = cur_reg.body_size[23:16];
                    2'd1:    byte_val = cur_reg.body_size[15:8];
                    2'd2:    byte_val = cur_reg.body_size[7:0];
                    default: byte_val = cur_reg.msg_type;
                endcase
                if (cur_reg.fmt == FMT_FULL) begin
                    sec_next = SEC_SID;
                    sec_done = 1'b0;
                end else begin
                    sec_done = !cur_reg.ext;
                end
            end
            SEC_SID: begin
                // little-endian stream id
                case (idx_reg)
                    2'd0:    byte_val = cur_reg.stream_id[7:0];
                    2'd1:    byte_val = cur_reg.stream_id[15:8];
                    2'd2:    byte_val = cur_reg.stream_id[23:16];
                    default: byte_val = cur_reg.stream_id[31:24];
                endcase
                sec_done = !cur_reg.ext;
            end
            SEC_EXT: begin
                case (idx_reg)
                    2'd0:    byte_val = cur_reg.timestamp[31:24];
                    2'd1:    byte_val = cur_reg.timestamp[23:16];
                    2'd2:    byte_val = cur_reg.timestamp[15:8];
                    default: byte_val = cur_reg.timestamp[7:0];
                endcase
                sec_done = 1'b1;
            end
            default: begin
                sec_done = 1'b1;
            end
        endcase
    end

    assign sec_end  = (idx_reg == sec_last);
    assign hdr_end  = sec_end && sec_done;
    assign load_cur = !cur_valid_reg || (emit && hdr_end);
    assign q_pop    = q_valid && load_cur;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            sec_reg       <= SEC_BASIC;
            idx_reg       <= 2'd0;
        end else begin
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (load_cur) begin
                cur_valid_reg <= q_valid;
                sec_reg       <= SEC_BASIC;
                idx_reg       <= 2'd0;
            end else if (emit) begin
                if (sec_end) begin
                    sec_reg <= sec_next;
                    idx_reg <= 2'd0;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_data;
        end
        if (emit) begin
            out_reg.header_byte <= byte_val;
            out_reg.last_byte   <= hdr_end;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// File: hdl/rtmp_chunk_header_builder_top.sv
// ----------------------------------------------------------------------------
// rtmp_chunk_header_builder_top: chunk header builder
// Turns message descriptors into compressed chunk header byte streams.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one message descriptor per beat (slot, chunk stream id,
//   stream id, timestamp, type, body size). m_ channel: one header byte per
//   beat, last_byte set on the final byte of each header (1 to 18 bytes).
//   The front stage reads the slot record from a RAM (one read port, one
//   write port), picks format 0..3 and writes the new record back when the
//   header is queued; a forward path covers back-to-back items on the
//   same slot. A two-entry queue hands the classified header to the byte
//   sequencer. Throughput: a descriptor can be taken every cycle until the
//   queue fills; sustained rate is one header byte per cycle while m_ready
//   is high, set by the single output port. The first header byte passes
//   through the front stage register, the queue, the sequencer's header
//   register and the output register.
//   Reset: all slot valid bits clear, so every slot starts with format 0; no
//   clearing pass is needed. When m_ready is low the output holds, the
//   sequencer stalls, the queue fills and s_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module rtmp_chunk_header_builder_top (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire rchb_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output rchb_pkg::out_t      m_data
);
    import rchb_pkg::*;

    // front -> queue
    logic q_push;
    hdr_t q_in;
    logic q_ready;
    // queue -> back
    logic q_pop;
    hdr_t q_out;
    logic q_valid;

    // Classify descriptors and update slot state
    rchb_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_data  (q_in),
        .q_ready (q_ready)
    );

    // Hold classified headers while the sequencer is busy
    rchb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .ready     (q_ready),
        .pop       (q_pop),
        .pop_data  (q_out),
        .valid     (q_valid)
    );

    // Serialize one byte per beat
    rchb_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTH
    // A queued header always has a 1, 2 or 3 byte basic header
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_in.bl != 2'd0))
        else $error("basic header length of zero queued");

    // Within a header the next byte is ready right after a beat is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last_byte) |=> m_valid)
        else $error("gap inside a header");

    // A full queue is never pushed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && !q_pop) |-> q_ready)
        else $error("push into full header queue");
`endif

endmodule

`default_nettype wire

// File: tb/rchb_tb_pkg.sv
// ----------------------------------------------------------------------------
// rchb_tb_pkg: header prediction and beat checking for the chunk header builder
// Keeps its own per-slot history, expands each accepted descriptor into the
// header bytes it must produce and compares every output beat in order.
// ----------------------------------------------------------------------------
package rchb_tb_pkg;

    import rchb_pkg::*;

    class chunk_header_scoreboard;

        // Per-slot history of the last accepted message
        bit          slot_seen [CHANNEL_SLOTS];
        logic [31:0] last_stream [CHANNEL_SLOTS];
        logic [31:0] last_time [CHANNEL_SLOTS];
        logic [31:0] last_delta [CHANNEL_SLOTS];
        logic [7:0]  last_type [CHANNEL_SLOTS];
        logic [23:0] last_size [CHANNEL_SLOTS];

        out_t header_bytes_due[$];
        int   errors;
        int   beats_checked;

        function new();
            foreach (slot_seen[i]) slot_seen[i] = 1'b0;
            errors = 0;
            beats_checked = 0;
        endfunction

        function int pending();
            return header_bytes_due.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) begin
                $display("ERROR: %s", msg);
            end
        endtask

        // Pick the header format, update the slot and queue the header bytes.
        function void note_message(in_t d);
            int          idx;
            logic [16:0] cid;
            logic [31:0] sid;
            logic [31:0] tval;
            logic [1:0]  fmt;
            logic        ext;
            logic [23:0] tfield;
            logic [15:0] rel;
            out_t        hdr[$];
            idx  = int'(d.channel_slot) % CHANNEL_SLOTS;
            cid  = d.channel_id;
            sid  = (cid == CID_FORCE_ZERO) ? 32'd0 : d.stream_id;
            tval = d.timestamp;
            fmt  = FMT_FULL;

            if (slot_seen[idx] && last_stream[idx] == sid && d.timestamp >= last_time[idx]) begin
                fmt  = FMT_NO_STREAM;
                tval = d.timestamp - last_time[idx];
                if (last_type[idx] == d.msg_type && last_size[idx] == d.body_size) begin
                    fmt = (last_delta[idx] == tval) ? FMT_CONT : FMT_DELTA;
                end
            end

            slot_seen[idx]   = 1'b1;
            last_stream[idx] = sid;
            last_time[idx]   = d.timestamp;
            last_delta[idx]  = tval;
            last_type[idx]   = d.msg_type;
            last_size[idx]   = d.body_size;

            ext    = (tval >= {8'd0, TIME_SAT});
            tfield = ext ? TIME_SAT : tval[23:0];

            // basic header: 1, 2 or 3 bytes depending on the chunk stream id
            if (cid > CID_TWO_MAX) begin
                rel = 16'(cid - CID_BIAS);
                hdr.push_back({fmt, 6'd1, 1'b0});
                hdr.push_back({rel[7:0], 1'b0});
                hdr.push_back({rel[15:8], 1'b0});
            end else if (cid > CID_ONE_MAX) begin
                rel = 16'(cid - CID_BIAS);
                hdr.push_back({fmt, 6'd0, 1'b0});
                hdr.push_back({rel[7:0], 1'b0});
            end else begin
                hdr.push_back({fmt, cid[5:0], 1'b0});
            end

            if (fmt != FMT_CONT) begin
                hdr.push_back({tfield[23:16], 1'b0});
                hdr.push_back({tfield[15:8], 1'b0});
                hdr.push_back({tfield[7:0], 1'b0});
                if (fmt == FMT_FULL || fmt == FMT_NO_STREAM) begin
                    hdr.push_back({d.body_size[23:16], 1'b0});
                    hdr.push_back({d.body_size[15:8], 1'b0});
                    hdr.push_back({d.body_size[7:0], 1'b0});
                    hdr.push_back({d.msg_type, 1'b0});
                    if (fmt == FMT_FULL) begin
                        hdr.push_back({sid[7:0], 1'b0});
                        hdr.push_back({sid[15:8], 1'b0});
                        hdr.push_back({sid[23:16], 1'b0});
                        hdr.push_back({sid[31:24], 1'b0});
                    end
                end
            end

            if (ext) begin
                hdr.push_back({d.timestamp[31:24], 1'b0});
                hdr.push_back({d.timestamp[23:16], 1'b0});
                hdr.push_back({d.timestamp[15:8], 1'b0});
                hdr.push_back({d.timestamp[7:0], 1'b0});
            end

            hdr[hdr.size() - 1].last_byte = 1'b1;
            foreach (hdr[i]) header_bytes_due.push_back(hdr[i]);
        endfunction

        task check_beat(out_t got);
            out_t want;
            beats_checked++;
            if (header_bytes_due.size() == 0) begin
                report($sformatf("beat %0d: unexpected byte %02h last %0b",
                                 beats_checked, got.header_byte, got.last_byte));
            end else begin
                want = header_bytes_due.pop_front();
                if (got.header_byte !== want.header_byte) begin
                    report($sformatf("beat %0d: header_byte %02h, expected %02h",
                                     beats_checked, got.header_byte, want.header_byte));
                end
                if (got.last_byte !== want.last_byte) begin
                    report($sformatf("beat %0d: last_byte %0b, expected %0b",
                                     beats_checked, got.last_byte, want.last_byte));
                end
            end
        endtask

    endclass

endpackage

// File: tb/tb_rtmp_chunk_header_builder_top.sv
// ----------------------------------------------------------------------------
// tb_rtmp_chunk_header_builder_top: chunk header builder testbench
// Drives message descriptors through the input channel, first a directed set
// covering every header format, basic header form and timestamp saturation,
// then random per-slot message sequences. Every header byte is checked
// against a prediction, with random idling on both sides, one long output
// hold-off and drain pauses on the input side.
// ----------------------------------------------------------------------------
module tb_rtmp_chunk_header_builder_top;

    import rchb_pkg::*;
    import rchb_tb_pkg::*;

    localparam int RANDOM_MESSAGES = 180;
    localparam int HOLD_OFF_AT     = 400;   // output beat that starts the long hold-off
    localparam int HOLD_OFF_CYCLES = 400;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // Idle enables for each side, switched per phase by the stimulus
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;

    chunk_header_scoreboard sb;

    rtmp_chunk_header_builder_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Hard stop in case the block wedges
    initial begin
        #4000000;
        $display("tb_rtmp_chunk_header_builder_top: FAIL");
        $finish;
    end

    function automatic in_t descriptor(input logic [5:0] slot, input logic [16:0] cid,
                                       input logic [31:0] sid, input logic [31:0] ts,
                                       input logic [7:0] mtype, input logic [23:0] size);
        in_t d;
        d.channel_slot = slot;
        d.channel_id   = cid;
        d.stream_id    = sid;
        d.timestamp    = ts;
        d.msg_type     = mtype;
        d.body_size    = size;
        return d;
    endfunction

    // Spread chunk stream ids over all basic header forms, plus the ids
    // outside the nominal range.
    function automatic logic [16:0] pick_channel_id();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return 17'($urandom_range(0, 1));
            1:       return CID_FORCE_ZERO;
            2, 3:    return 17'($urandom_range(3, 63));
            4, 5:    return 17'($urandom_range(64, 319));
            6, 7:    return 17'($urandom_range(320, 65599));
            default: return 17'($urandom);
        endcase
    endfunction

    // Build a random descriptor. Most of them continue the history of a slot
    // that already carries a message, so that the compressed formats come up;
    // the rest are fresh messages. Some continued ones turn time back or switch stream.
    function automatic in_t next_message();
        in_t         d;
        int          idx;
        int          roll;
        logic [31:0] delta;
        logic [31:0] back;
        logic [32:0] sum;
        d.channel_slot = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
        d.channel_id   = pick_channel_id();
        d.stream_id    = $urandom;
        d.timestamp    = ($urandom_range(0, 9) < 7) ? 32'($urandom_range(0, 100000)) : $urandom;
        d.msg_type     = 8'($urandom);
        d.body_size    = 24'($urandom);
        idx = int'(d.channel_slot) % CHANNEL_SLOTS;

        if (sb.slot_seen[idx] && $urandom_range(0, 99) < 80) begin
            d.stream_id = sb.last_stream[idx];
            roll = $urandom_range(0, 9);
            if (roll < 5) begin
                delta = sb.last_delta[idx];
            end else if (roll < 8) begin
                delta = 32'($urandom_range(1, 5000));
            end else if (roll < 9) begin
                delta = 32'($urandom_range(32'h00FF_FFF0, 32'h0300_0000));
            end else begin
                delta = 32'd0;
            end
            sum = {1'b0, sb.last_time[idx]} + {1'b0, delta};
            d.timestamp = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

            if ($urandom_range(0, 9) < 6) begin
                d.msg_type  = sb.last_type[idx];
                d.body_size = sb.last_size[idx];
            end

            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                back = 32'($urandom_range(1, 1000));
                d.timestamp = (sb.last_time[idx] > back) ? sb.last_time[idx] - back : 32'd0;
            end else if (roll < 10) begin
                d.stream_id = d.stream_id ^ (32'd1 << $urandom_range(0, 31));
            end
        end
        return d;
    endfunction

    // Offer one descriptor after a random gap and hold it until accepted.
    task automatic send_message(input in_t d);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
        sb.note_message(d);
    endtask

    // Hold the input side until every predicted byte has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Output side: stall at random before each beat, once for a long stretch
    // so the internal queue fills and the input side backs up.
    initial begin
        int  stall;
        int  beats_taken;
        bit  hold_done;
        beats_taken = 0;
        hold_done   = 1'b0;
        wait (aresetn);
        forever begin
            if (!hold_done && beats_taken >= HOLD_OFF_AT) begin
                hold_done = 1'b1;
                stall = HOLD_OFF_CYCLES;
            end else begin
                stall = rx_idle_on ? $urandom_range(0, 8) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_beat(m_data);
            beats_taken++;
        end
    end

    initial begin
        in_t directed[$];
        sb = new();

        // Hold reset at start, then release it for good
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every slot starts invalid, so first touches give format 0
        directed.push_back(descriptor(6'd0, 17'd0, 32'd0, 32'd0, 8'h00, 24'h000000));
        directed.push_back(descriptor(6'd63, 17'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      8'hFF, 24'hFFFFFF));
        // Channel two forces stream id 0, so a differing stream id still compresses
        directed.push_back(descriptor(6'd1, 17'd2, 32'h1234_5678, 32'd100, 8'h08, 24'd50));
        directed.push_back(descriptor(6'd1, 17'd2, 32'hDEAD_BEEF, 32'd140, 8'h08, 24'd60));
        directed.push_back(descriptor(6'd1, 17'd2, 32'h0, 32'd200, 8'h08, 24'd60));
        directed.push_back(descriptor(6'd1, 17'd2, 32'h0, 32'd260, 8'h08, 24'd60));
        // Time going back falls back to a full header
        directed.push_back(descriptor(6'd1, 17'd2, 32'h0, 32'd250, 8'h08, 24'd60));
        // Stream change on the same slot
        directed.push_back(descriptor(6'd2, 17'd63, 32'd5, 32'd1000, 8'h14, 24'd7));
        directed.push_back(descriptor(6'd2, 17'd64, 32'd6, 32'd1000, 8'h14, 24'd7));
        // Saturated time field with extended timestamp on each format
        directed.push_back(descriptor(6'd3, 17'd319, 32'd7, 32'h00FF_FFFF, 8'h09, 24'd3));
        directed.push_back(descriptor(6'd3, 17'd320, 32'd7, 32'h01FF_FFFE, 8'h0A, 24'd3));
        directed.push_back(descriptor(6'd3, 17'd65599, 32'd7, 32'h02FF_FFFD, 8'h0A, 24'd3));
        directed.push_back(descriptor(6'd3, 17'd65600, 32'd7, 32'h03FF_FFFD, 8'h0A, 24'd3));
        // Ids past the nominal range wrap in the 3-byte form; longest header
        directed.push_back(descriptor(6'd4, 17'h1FFFF, 32'hA5A5_A5A5, 32'd5, 8'h12, 24'h800001));
        directed.push_back(descriptor(6'd5, 17'h1FFFF, 32'h0102_0304, 32'hFFFF_FFFF,
                                      8'h5A, 24'h5A5A5A));
        // Time value just below saturation
        directed.push_back(descriptor(6'd42, 17'd100, 32'h5A5A_5A5A, 32'h00FF_FFFE,
                                      8'h01, 24'h010203));
        directed.push_back(descriptor(6'd21, 17'd65, 32'h0, 32'h0, 8'h80, 24'h000001));

        foreach (directed[i]) send_message(directed[i]);

        // Pause the input side until the directed headers are all out
        wait_drained();

        // Random: alternate blocks with and without idling on each side
        for (int n = 0; n < RANDOM_MESSAGES; n++) begin
            if (n % 30 == 0) begin
                tx_idle_on = ((n / 30) % 3) != 1;
                rx_idle_on = ((n / 30) % 3) != 2;
            end
            if (n == RANDOM_MESSAGES / 2) begin
                wait_drained();
            end
            send_message(next_message());
        end
        s_valid <= 1'b0;

        // Let the last headers come out, then leave room for any stray beat
        while (sb.pending() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("tb_rtmp_chunk_header_builder_top: PASS");
        end else begin
            $display("tb_rtmp_chunk_header_builder_top: FAIL");
        end
        $finish;
    end

endmodule
